// File: rtl/ktbl_pkg.sv
// Shared constants and types for the keyed token bucket limiter.
package ktbl_pkg;

    localparam int NUM_ENTRIES     = 64;
    localparam int KEY_BITS        = 64;
    localparam int TIME_BITS       = 32;
    localparam int RATE_BITS       = 16;
    localparam int TOKEN_BITS      = 22;
    localparam int UNITS_PER_TOKEN = 60;
    localparam int IDX_BITS        = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_BITS        = $clog2(NUM_ENTRIES + 1);
    localparam int EL_BITS         = $clog2(UNITS_PER_TOKEN);

    localparam logic [TOKEN_BITS-1:0] TOKEN_COST = TOKEN_BITS'(UNITS_PER_TOKEN);
    localparam logic [TIME_BITS-1:0]  FULL_GAP   = TIME_BITS'(UNITS_PER_TOKEN);
    localparam logic [CNT_BITS-1:0]   TABLE_FULL = CNT_BITS'(NUM_ENTRIES);

    // One bucket as it sits in the table memory.
    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [TOKEN_BITS-1:0] tokens;
        logic [TIME_BITS-1:0]  stamp;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    // Work handed to the bucket arithmetic unit.
    typedef struct packed {
        logic                  start;
        logic [TOKEN_BITS-1:0] tokens;
        logic [TIME_BITS-1:0]  stamp;
        logic [TIME_BITS-1:0]  now;
        logic [RATE_BITS-1:0]  rate;
        logic [TOKEN_BITS-1:0] cap;
    } alu_req_t;

    // Answer from the bucket arithmetic unit.
    typedef struct packed {
        logic                  done;
        logic                  allowed;
        logic [TOKEN_BITS-1:0] tokens;
        logic [TIME_BITS-1:0]  stamp;
    } alu_rsp_t;

endpackage

// File: rtl/ktbl_if.sv
// Valid/ready channel interfaces for requests and decisions.
interface ktbl_req_if;
    logic                           valid;
    logic                           ready;
    logic [ktbl_pkg::KEY_BITS-1:0]  flow_key;
    logic [ktbl_pkg::TIME_BITS-1:0] now_seconds;

    modport source (output valid, output flow_key, output now_seconds, input ready);
    modport sink (input valid, input flow_key, input now_seconds, output ready);
endinterface

interface ktbl_resp_if;
    logic valid;
    logic ready;
    logic allowed;

    modport source (output valid, output allowed, input ready);
    modport sink (input valid, input allowed, output ready);
endinterface

// File: rtl/ktbl_ram.sv
// Generic single-write, single-read memory with registered read data.
module ktbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/ktbl_bucket_alu.sv
// Three-step refill, cap and spend arithmetic for one bucket.
module ktbl_bucket_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  ktbl_pkg::alu_req_t req,
    output ktbl_pkg::alu_rsp_t rsp
);
    import ktbl_pkg::*;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  gt1_reg, big1_reg;
    logic [TOKEN_BITS-1:0] prod1_reg, tokens1_reg, cap1_reg;
    logic [TIME_BITS-1:0]  stamp1_reg, stamp2_reg, stamp3_reg;
    logic [TOKEN_BITS-1:0] new2_reg, tokens3_reg;
    logic                  allowed3_reg;

    logic [TIME_BITS-1:0]  elapsed;
    logic [TOKEN_BITS:0]   sum;
    logic [TOKEN_BITS-1:0] refilled;
    logic                  can_spend;

    // Elapsed time; only its low bits matter when it is below a full refill.
    assign elapsed = req.now - req.stamp;

    // Refill with the cap, keeping the count when time did not advance.
    always_comb
    begin
        sum = {1'b0, tokens1_reg} + {1'b0, prod1_reg};
        if (!gt1_reg)
        begin
            refilled = tokens1_reg;
        end
        else if (big1_reg || (sum > {1'b0, cap1_reg}))
        begin
            refilled = cap1_reg;
        end
        else
        begin
            refilled = sum[TOKEN_BITS-1:0];
        end
    end

    assign can_spend = (new2_reg >= TOKEN_COST);

    // Step valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Step data.
    always_ff @(posedge clk)
    begin
        gt1_reg     <= (req.now > req.stamp);
        big1_reg    <= (elapsed >= FULL_GAP);
        prod1_reg   <= TOKEN_BITS'(elapsed[EL_BITS-1:0] * req.rate);
        tokens1_reg <= req.tokens;
        cap1_reg    <= req.cap;
        stamp1_reg  <= (req.now > req.stamp) ? req.now : req.stamp;

        new2_reg    <= refilled;
        stamp2_reg  <= stamp1_reg;

        allowed3_reg <= can_spend;
        tokens3_reg  <= can_spend ? (new2_reg - TOKEN_COST) : new2_reg;
        stamp3_reg   <= stamp2_reg;
    end

    assign rsp.done    = v3_reg;
    assign rsp.allowed = allowed3_reg;
    assign rsp.tokens  = tokens3_reg;
    assign rsp.stamp   = stamp3_reg;

endmodule

// File: rtl/keyed_token_bucket_limiter_unit.sv
// Keyed token bucket limiter: table scan sequencer, bucket memory and arithmetic.
// With limiting disabled the accepted request goes straight to an allowed decision.
// Otherwise the scan reads one entry per cycle: a hit runs the bucket arithmetic and
// writes the entry back, while a miss claims a free entry or evicts the oldest one.
// One request at a time; the next is taken once the decision is posted.
// Reset clears the rate register and the fill count; table contents are not cleared.
module keyed_token_bucket_limiter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    ktbl_req_if.sink                       req,
    ktbl_resp_if.source                    resp,
    input  logic                           cfg_we,
    input  logic [ktbl_pkg::RATE_BITS-1:0] cfg_wdata
);
    import ktbl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ALU,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [RATE_BITS-1:0]  rate_reg;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [TOKEN_BITS-1:0] cap_reg, cap_next;
    logic [CNT_BITS-1:0]   used_reg, used_next;
    logic [CNT_BITS-1:0]   issue_reg, issue_next;
    logic                  pv_reg, pv_next;
    logic [IDX_BITS-1:0]   pidx_reg, pidx_next;
    logic [TIME_BITS-1:0]  min_time_reg, min_time_next;
    logic [IDX_BITS-1:0]   min_idx_reg, min_idx_next;
    logic [IDX_BITS-1:0]   slot_reg, slot_next;
    logic                  result_reg, result_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_allowed_reg, out_allowed_next;

    logic                  ram_we, ram_re;
    logic [IDX_BITS-1:0]   ram_waddr, ram_raddr;
    entry_t                ram_wdata, ram_rdata;
    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;

    logic                  accept;
    logic                  hit;
    logic                  scan_done;
    logic                  full;
    logic [TOKEN_BITS:0]   cap_calc;

    assign req.ready    = (state_reg == ST_IDLE);
    assign accept       = req.valid && req.ready;
    assign resp.valid   = out_valid_reg;
    assign resp.allowed = out_allowed_reg;

    // Capacity in 1/60-token units: rate * 64 - rate * 4.
    assign cap_calc = ({{(TOKEN_BITS + 1 - RATE_BITS){1'b0}}, rate_reg} << 6)
                    - ({{(TOKEN_BITS + 1 - RATE_BITS){1'b0}}, rate_reg} << 2);

    assign full      = (used_reg == TABLE_FULL);
    assign hit       = pv_reg && (ram_rdata.key == key_reg);
    assign scan_done = !pv_reg && (issue_reg == used_reg);

    // Scan reads, one table entry per cycle until a hit.
    assign ram_re    = (state_reg == ST_SCAN) && (issue_reg < used_reg) && !hit;
    assign ram_raddr = issue_reg[IDX_BITS-1:0];

    ktbl_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (NUM_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ktbl_bucket_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // Sequencer next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        key_next         = key_reg;
        now_next         = now_reg;
        cap_next         = cap_reg;
        used_next        = used_reg;
        issue_next       = issue_reg;
        pv_next          = 1'b0;
        pidx_next        = pidx_reg;
        min_time_next    = min_time_reg;
        min_idx_next     = min_idx_reg;
        slot_next        = slot_reg;
        result_next      = result_reg;
        out_valid_next   = out_valid_reg && !resp.ready;
        out_allowed_next = out_allowed_reg;
        ram_we           = 1'b0;
        ram_waddr        = slot_reg;
        ram_wdata        = '{key: key_reg, tokens: alu_rsp.tokens, stamp: alu_rsp.stamp};
        alu_req          = '{start: 1'b0, tokens: ram_rdata.tokens, stamp: ram_rdata.stamp,
                             now: now_reg, rate: rate_reg, cap: cap_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next   = req.flow_key;
                    now_next   = req.now_seconds;
                    cap_next   = cap_calc[TOKEN_BITS-1:0];
                    issue_next = '0;
                    if (rate_reg == '0)
                    begin
                        result_next = 1'b1;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (ram_re)
                begin
                    pv_next    = 1'b1;
                    pidx_next  = issue_reg[IDX_BITS-1:0];
                    issue_next = issue_reg + 1'b1;
                end
                // Track the oldest entry, keeping the first on a tie.
                if (pv_reg && !hit && ((pidx_reg == '0) || (ram_rdata.stamp < min_time_reg)))
                begin
                    min_time_next = ram_rdata.stamp;
                    min_idx_next  = pidx_reg;
                end
                if (hit)
                begin
                    alu_req.start = 1'b1;
                    slot_next     = pidx_reg;
                    state_next    = ST_ALU;
                end
                else if (scan_done)
                begin
                    // Miss: claim a free entry or evict the oldest; it starts full less the token spent.
                    ram_we      = 1'b1;
                    ram_waddr   = full ? min_idx_reg : used_reg[IDX_BITS-1:0];
                    ram_wdata   = '{key: key_reg, tokens: cap_reg - TOKEN_COST, stamp: now_reg};
                    used_next   = full ? used_reg : used_reg + 1'b1;
                    result_next = 1'b1;
                    state_next  = ST_FINISH;
                end
            end

            ST_ALU:
            begin
                if (alu_rsp.done)
                begin
                    ram_we      = 1'b1;
                    result_next = alu_rsp.allowed;
                    state_next  = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || resp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_allowed_next = result_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= '0;
            used_reg      <= '0;
            issue_reg     <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            issue_reg     <= issue_next;
            pv_reg        <= pv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                rate_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        now_reg         <= now_next;
        cap_reg         <= cap_next;
        pidx_reg        <= pidx_next;
        min_time_reg    <= min_time_next;
        min_idx_reg     <= min_idx_next;
        slot_reg        <= slot_next;
        result_reg      <= result_next;
        out_allowed_reg <= out_allowed_next;
    end

    // The fill count never passes the table size.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= TABLE_FULL)
        else $error("fill count exceeds table size");

    // The table is written only when a scan ends or the arithmetic finishes.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_SCAN || state_reg == ST_ALU))
        else $error("table write outside scan or update");

    // The arithmetic unit answers only while the sequencer waits for it.
    a_alu_done: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == ST_ALU))
        else $error("arithmetic result with no request pending");

    // A miss with a full table leaves the fill count unchanged.
    a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && full) |=> full)
        else $error("fill count changed while table full");

endmodule
